// ----- hw/rtl/gbp_pkg.sv -----
// Shared constants, codes and the tap position function of the Gaussian blur pixel core.
package gbp_pkg;

    localparam int COORD_W = 9;
    localparam int KSIZE_W = 5;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 24;
    localparam int WT_W    = 16;
    localparam int PROD_W  = WT_W + CH_W;
    localparam int FRAC_W  = 16;

    localparam logic [1:0] FUNC_PIXEL  = 2'd0;
    localparam logic [1:0] FUNC_WEIGHT = 2'd1;
    localparam logic [1:0] FUNC_FILTER = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KSIZE  = 2'd2;

    localparam logic [COORD_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [KSIZE_W-1:0] KSIZE_RST  = 5'd5;

    // mirror a tap about the centre when outside, then clamp to the edge
    function automatic logic [COORD_W-1:0] tap_pos(
        input logic [7:0]         c,
        input logic [KSIZE_W-1:0] k,
        input logic [KSIZE_W-1:0] half,
        input logic [COORD_W-1:0] n
    );
        logic signed [11:0] t;
        logic signed [11:0] sn;
        t  = $signed({4'b0, c}) + $signed({7'b0, k}) - $signed({7'b0, half});
        sn = $signed({3'b0, n});
        if (t < 12'sd0 || t >= sn)
        begin
            t = $signed({4'b0, c}) + $signed({7'b0, half}) - $signed({7'b0, k});
        end
        if (t < 12'sd0)
        begin
            t = 12'sd0;
        end
        else if (t >= sn)
        begin
            t = sn - 12'sd1;
        end
        return t[COORD_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/gbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/gaussian_blur_pixel_core.sv -----
// Top level of the Gaussian blur pixel core: sequencer, address unit and shared MAC datapath.
//
// Each input word is one of three kinds: a pixel write (func 0), a kernel weight write
// (func 1) or a filter request at (x, y) (func 2); every word returns exactly one result
// word, the filtered RGB pixel for a filter request and a zero acknowledge for all others.
// A write passes the write and response states to a ready output register. A filter
// request for a kernel side s sends one tap per cycle through a single address multiplier,
// one read port of the image RAM and one three-channel multiply-accumulate, followed
// by a pipeline drain and a rounding step as the output register is loaded.
// The input is stalled while an item is in progress; a finished result may wait in the
// output register while the next word is accepted. Configuration is written through a
// separate port that is always ready.
module gaussian_blur_pixel_core #(
    parameter int IMAGE_SIDE  = 256,
    parameter int KERNEL_SIDE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [gbp_pkg::COORD_W-1:0] cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [7:0]                  x,
    input  logic [7:0]                  y,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    input  logic [15:0]                 weight,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        is_filtered,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue
);

    localparam int IMG_DEPTH = IMAGE_SIDE * IMAGE_SIDE;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int KER_DEPTH = KERNEL_SIDE * KERNEL_SIDE;
    localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
    localparam int LIN_W     = (IMG_AW > 2 * gbp_pkg::COORD_W + 1) ?
                               IMG_AW : 2 * gbp_pkg::COORD_W + 1;
    localparam int ACC_W     = gbp_pkg::PROD_W + ((KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 0);
    localparam int CW        = gbp_pkg::COORD_W;
    localparam int KW        = gbp_pkg::KSIZE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WR    = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] width_reg, height_reg;
    logic [KW-1:0] ksize_reg;

    logic [1:0]    func_reg, func_next;
    logic          wr_ok_reg, wr_ok_next;
    logic [7:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic [CW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [KER_AW-1:0] kaddr_reg, kaddr_next;
    logic [gbp_pkg::PIX_W-1:0] pix_wr_reg, pix_wr_next;
    logic [gbp_pkg::WT_W-1:0]  wt_wr_reg, wt_wr_next;
    logic [KW-1:0] ti_reg, ti_next, tj_reg, tj_next;
    logic [2:0]    pipe_v_reg, pipe_v_next;

    logic [gbp_pkg::PROD_W-1:0] prod_reg [3];
    logic [ACC_W-1:0]           acc_reg [3];
    logic                       acc_clr;

    logic          out_valid_reg, out_valid_next;
    logic          is_filt_reg;
    logic [7:0]    out_ch_reg [3];
    logic [7:0]    chan_res [3];
    logic          out_load;

    logic [CW-1:0] w_eff, h_eff;
    logic [KW-1:0] s_eff, half;
    logic          accept;
    logic          last_tap;

    logic [LIN_W-1:0]  img_lin;
    logic [IMG_AW-1:0] img_addr;
    logic              img_we, ker_we;
    logic [gbp_pkg::PIX_W-1:0] img_rdata;
    logic [gbp_pkg::WT_W-1:0]  ker_rdata;

    // effective register values
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = CW'(1);
        else if (int'(width_reg) > IMAGE_SIDE)
            w_eff = CW'(IMAGE_SIDE);
        else
            w_eff = width_reg;

        priority if (height_reg == '0)
            h_eff = CW'(1);
        else if (int'(height_reg) > IMAGE_SIDE)
            h_eff = CW'(IMAGE_SIDE);
        else
            h_eff = height_reg;

        priority if (ksize_reg == '0)
            s_eff = KW'(1);
        else if (int'(ksize_reg) > KERNEL_SIDE)
            s_eff = KW'(KERNEL_SIDE);
        else
            s_eff = ksize_reg;

        half = s_eff >> 1;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign last_tap  = (ti_reg == s_eff - KW'(1)) && (tj_reg == s_eff - KW'(1));

    // shared address unit: row times width plus column
    assign img_lin  = LIN_W'(pos_y_reg) * LIN_W'(w_eff) + LIN_W'(pos_x_reg);
    assign img_addr = img_lin[IMG_AW-1:0];
    assign img_we   = (state_reg == ST_WR) && (func_reg == gbp_pkg::FUNC_PIXEL) && wr_ok_reg;
    assign ker_we   = (state_reg == ST_WR) && (func_reg == gbp_pkg::FUNC_WEIGHT) && wr_ok_reg;

    gbp_ram #(
        .WIDTH (gbp_pkg::PIX_W),
        .DEPTH (IMG_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_addr),
        .wdata (pix_wr_reg),
        .raddr (img_addr),
        .rdata (img_rdata)
    );

    gbp_ram #(
        .WIDTH (gbp_pkg::WT_W),
        .DEPTH (KER_DEPTH)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (ker_we),
        .waddr (kaddr_reg),
        .wdata (wt_wr_reg),
        .raddr (kaddr_reg),
        .rdata (ker_rdata)
    );

    // round half up, drop the fraction, clip to a byte
    always_comb
    begin
        logic [ACC_W:0] rnd;
        for (int c = 0; c < 3; c++)
        begin
            rnd = (ACC_W + 1)'(acc_reg[c]) + (ACC_W + 1)'(1 << (gbp_pkg::FRAC_W - 1));
            chan_res[c] = (|rnd[ACC_W:gbp_pkg::FRAC_W + 8]) ?
                          8'hFF : rnd[gbp_pkg::FRAC_W + 7:gbp_pkg::FRAC_W];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        wr_ok_next  = wr_ok_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        kaddr_next  = kaddr_reg;
        pix_wr_next = pix_wr_reg;
        wt_wr_next  = wt_wr_reg;
        ti_next     = ti_reg;
        tj_next     = tj_reg;
        pipe_v_next = {pipe_v_reg[1:0], 1'b0};
        acc_clr     = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func;
                    cx_next     = x;
                    cy_next     = y;
                    pos_x_next  = {1'b0, x};
                    pos_y_next  = {1'b0, y};
                    kaddr_next  = KER_AW'(y) * KER_AW'(KERNEL_SIDE) + KER_AW'(x);
                    pix_wr_next = {red, green, blue};
                    wt_wr_next  = weight;
                    ti_next     = '0;
                    tj_next     = '0;
                    unique case (func)
                        gbp_pkg::FUNC_PIXEL:
                        begin
                            wr_ok_next = ({1'b0, x} < w_eff) && ({1'b0, y} < h_eff);
                            state_next = ST_WR;
                        end
                        gbp_pkg::FUNC_WEIGHT:
                        begin
                            wr_ok_next = (int'(x) < KERNEL_SIDE) && (int'(y) < KERNEL_SIDE);
                            state_next = ST_WR;
                        end
                        gbp_pkg::FUNC_FILTER:
                        begin
                            wr_ok_next = 1'b0;
                            acc_clr    = 1'b1;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            wr_ok_next = 1'b0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_WR:
            begin
                state_next = ST_RESP;
            end
            ST_RUN:
            begin
                pos_x_next     = gbp_pkg::tap_pos(cx_reg, ti_reg, half, w_eff);
                pos_y_next     = gbp_pkg::tap_pos(cy_reg, tj_reg, half, h_eff);
                kaddr_next     = KER_AW'(tj_reg) * KER_AW'(KERNEL_SIDE) + KER_AW'(ti_reg);
                pipe_v_next[0] = 1'b1;
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
                else if (tj_reg == s_eff - KW'(1))
                begin
                    tj_next = '0;
                    ti_next = ti_reg + KW'(1);
                end
                else
                begin
                    tj_next = tj_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (pipe_v_reg == '0)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pipe_v_reg    <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= gbp_pkg::WIDTH_RST;
            height_reg    <= gbp_pkg::HEIGHT_RST;
            ksize_reg     <= gbp_pkg::KSIZE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pipe_v_reg    <= pipe_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gbp_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    gbp_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    gbp_pkg::CFG_KSIZE:  ksize_reg  <= cfg_data[KW-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        wr_ok_reg  <= wr_ok_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        kaddr_reg  <= kaddr_next;
        pix_wr_reg <= pix_wr_next;
        wt_wr_reg  <= wt_wr_next;
        ti_reg     <= ti_next;
        tj_reg     <= tj_next;
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= gbp_pkg::PROD_W'(ker_rdata) *
                           gbp_pkg::PROD_W'(img_rdata[gbp_pkg::PIX_W - 1 - 8 * c -: 8]);
            if (acc_clr)
                acc_reg[c] <= '0;
            else if (pipe_v_reg[2])
                acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
        end
        if (out_load)
        begin
            is_filt_reg <= (func_reg == gbp_pkg::FUNC_FILTER);
            for (int c = 0; c < 3; c++)
            begin
                out_ch_reg[c] <= (func_reg == gbp_pkg::FUNC_FILTER) ? chan_res[c] : 8'h00;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_filtered = is_filt_reg;
    assign out_red     = out_ch_reg[0];
    assign out_green   = out_ch_reg[1];
    assign out_blue    = out_ch_reg[2];

endmodule
